// ===== rtl/bpfc_pkg.sv =====
package bpfc_pkg;

  localparam int CW = 24;
  localparam int AW = 16;
  localparam int CORDIC_STEPS = 31;
  localparam int SQRT_STEPS = CW + 1;
  localparam int NCELLS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int SCALE_SH = 56 - CW;
  localparam int XW = 60;
  localparam int ZW = 34;
  localparam int RW = CW + 1;
  localparam int NW = 2 * CW + 2;
  localparam int HS = 32 - AW;

  typedef struct packed {
    logic signed [CW-1:0] corner0_x;
    logic signed [CW-1:0] corner0_y;
    logic signed [CW-1:0] corner1_x;
    logic signed [CW-1:0] corner1_y;
    logic signed [CW-1:0] corner2_x;
    logic signed [CW-1:0] corner2_y;
  } corners_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [AW-1:0] heading;
    logic [RW-1:0]        length_first_side;
    logic [RW-1:0]        length_second_side;
  } pose_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [NW-1:0]        rem1;
    logic [NW-1:0]        rem2;
    logic [RW-1:0]        r1;
    logic [RW-1:0]        r2;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } cell_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [31:0] bpfc_atan(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'd536870912;
      1: t = 32'd316933406;
      2: t = 32'd167458907;
      3: t = 32'd85004756;
      4: t = 32'd42667331;
      5: t = 32'd21354465;
      6: t = 32'd10680862;
      7: t = 32'd5340245;
      8: t = 32'd2670163;
      9: t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41721;
      15: t = 32'd20860;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2607;
      19: t = 32'd1303;
      20: t = 32'd651;
      21: t = 32'd325;
      22: t = 32'd162;
      23: t = 32'd81;
      24: t = 32'd40;
      25: t = 32'd20;
      26: t = 32'd10;
      27: t = 32'd5;
      28: t = 32'd2;
      29: t = 32'd1;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/box_pose_from_corners_core.sv =====
// channel  | handshake                      | payload
// request  | corners_valid / corners_stall  | corners (corners_t)
// result   | pose_valid / pose_stall        | pose (pose_t)
//
// one request per cycle while corners_stall is low; each result passes through the front
// stage, the row of cordic / square-root cells and the back stage, each registered
// reset clears the stage valid bits only
// a stalled result freezes the whole row, so corners_stall is pose_stall gated by pose_valid
module box_pose_from_corners_core import bpfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     corners_valid,
  output logic     corners_stall,
  input  corners_t corners,
  output logic     pose_valid,
  input  logic     pose_stall,
  output pose_t    pose
);

  logic        adv;
  logic        v   [NCELLS+1];
  cell_t       d   [NCELLS+1];

  assign adv = !(pose_valid && pose_stall);
  assign corners_stall = !adv;

  bpfc_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .vin(corners_valid), .req(corners),
    .vout(v[0]), .dout(d[0])
  );

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    bpfc_cell #(.STEP(k)) u_cell (
      .clk(clk), .rst(rst), .adv(adv), .vin(v[k]), .din(d[k]),
      .vout(v[k+1]), .dout(d[k+1])
    );
  end

  bpfc_back u_back (
    .clk(clk), .rst(rst), .adv(adv), .vin(v[NCELLS]), .din(d[NCELLS]),
    .vout(pose_valid), .dout(pose)
  );

endmodule

// ===== rtl/bpfc_front.sv =====
module bpfc_front import bpfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     vin,
  input  corners_t req,
  output logic     vout,
  output cell_t    dout
);

  logic signed [CW:0]   dx, dy, ax1, ay1, ax2, ay2;
  logic [CW:0]          mx1, my1, mx2, my2;
  logic signed [XW-1:0] sx, sy;
  logic [NW-1:0]        n1, n2;
  logic signed [CW:0]   sumx, sumy;
  cell_t                d_next;

  always_comb begin
    dx  = $signed({req.corner1_x[CW-1], req.corner1_x}) -
          $signed({req.corner2_x[CW-1], req.corner2_x});
    dy  = $signed({req.corner1_y[CW-1], req.corner1_y}) -
          $signed({req.corner2_y[CW-1], req.corner2_y});
    ax1 = $signed({req.corner0_x[CW-1], req.corner0_x}) -
          $signed({req.corner1_x[CW-1], req.corner1_x});
    ay1 = $signed({req.corner0_y[CW-1], req.corner0_y}) -
          $signed({req.corner1_y[CW-1], req.corner1_y});
    ax2 = $signed({req.corner2_x[CW-1], req.corner2_x}) -
          $signed({req.corner1_x[CW-1], req.corner1_x});
    ay2 = $signed({req.corner2_y[CW-1], req.corner2_y}) -
          $signed({req.corner1_y[CW-1], req.corner1_y});
    mx1 = ax1[CW] ? (CW+1)'(-ax1) : (CW+1)'(ax1);
    my1 = ay1[CW] ? (CW+1)'(-ay1) : (CW+1)'(ay1);
    mx2 = ax2[CW] ? (CW+1)'(-ax2) : (CW+1)'(ax2);
    my2 = ay2[CW] ? (CW+1)'(-ay2) : (CW+1)'(ay2);
    n1  = NW'(mx1 * mx1) + NW'(my1 * my1);
    n2  = NW'(mx2 * mx2) + NW'(my2 * my2);
    sumx = $signed({req.corner0_x[CW-1], req.corner0_x}) +
           $signed({req.corner2_x[CW-1], req.corner2_x});
    sumy = $signed({req.corner0_y[CW-1], req.corner0_y}) +
           $signed({req.corner2_y[CW-1], req.corner2_y});
    sx = XW'(dx) <<< SCALE_SH;
    sy = XW'(dy) <<< SCALE_SH;

    d_next      = '0;
    d_next.cx   = sumx[CW:1];
    d_next.cy   = sumy[CW:1];
    d_next.rem1 = n1;
    d_next.rem2 = n2;
    d_next.r1   = '0;
    d_next.r2   = '0;
    // left half plane: pre-rotate by pi
    if (dx[CW]) begin
      d_next.x = -sx;
      d_next.y = -sy;
      d_next.z = dy[CW] ? -(ZW'(1) <<< 31) : (ZW'(1) <<< 31);
    end else begin
      d_next.x = sx;
      d_next.y = sy;
      d_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= d_next;
    end
  end

endmodule

// ===== rtl/bpfc_cell.sv =====
module bpfc_cell import bpfc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  vin,
  input  cell_t din,
  output logic  vout,
  output cell_t dout
);

  localparam bit DO_ROT = (STEP < CORDIC_STEPS);
  localparam bit DO_SQRT = (STEP <= CW);
  localparam int B = DO_SQRT ? (CW - STEP) : 0;
  localparam int SH = DO_ROT ? STEP : 0;
  localparam logic signed [ZW-1:0] ANG = ZW'(bpfc_atan(STEP));

  logic signed [XW-1:0] xs, ys;
  logic [NW:0]          t1, t2;
  cell_t                d_next;

  always_comb begin
    d_next = din;
    xs = din.x >>> SH;
    ys = din.y >>> SH;
    t1 = ({(NW+1-RW)'(0), din.r1} << (B + 1)) + ((NW+1)'(1) << (2 * B));
    t2 = ({(NW+1-RW)'(0), din.r2} << (B + 1)) + ((NW+1)'(1) << (2 * B));
    if (DO_ROT) begin
      if (!din.y[XW-1] && din.y != '0) begin
        d_next.x = din.x + ys;
        d_next.y = din.y - xs;
        d_next.z = din.z + ANG;
      end else if (din.y[XW-1]) begin
        d_next.x = din.x - ys;
        d_next.y = din.y + xs;
        d_next.z = din.z - ANG;
      end
    end
    // one root bit per cell, remainder kept as n - r^2
    if (DO_SQRT) begin
      if ({1'b0, din.rem1} >= t1) begin
        d_next.rem1 = din.rem1 - t1[NW-1:0];
        d_next.r1   = din.r1 | (RW'(1) << B);
      end
      if ({1'b0, din.rem2} >= t2) begin
        d_next.rem2 = din.rem2 - t2[NW-1:0];
        d_next.r2   = din.r2 | (RW'(1) << B);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= d_next;
    end
  end

endmodule

// ===== rtl/bpfc_back.sv =====
module bpfc_back import bpfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  vin,
  input  cell_t din,
  output logic  vout,
  output pose_t dout
);

  localparam logic signed [ZW-1:0] HMAX = ZW'((64'sd1 <<< (AW - 1)) - 1);
  localparam logic signed [ZW-1:0] HMIN = -(ZW'(1) <<< (AW - 1));

  logic signed [ZW-1:0] zr, h;
  pose_t                d_next;

  always_comb begin
    zr = din.z + (ZW'(1) <<< (HS - 1));
    h  = zr >>> HS;
    d_next.center_x = din.cx;
    d_next.center_y = din.cy;
    if (h > HMAX) begin
      d_next.heading = HMAX[AW-1:0];
    end else if (h < HMIN) begin
      d_next.heading = HMIN[AW-1:0];
    end else begin
      d_next.heading = h[AW-1:0];
    end
    // round to nearest: n - r^2 > r
    d_next.length_first_side  = (din.rem1 > NW'(din.r1)) ? din.r1 + RW'(1) : din.r1;
    d_next.length_second_side = (din.rem2 > NW'(din.r2)) ? din.r2 + RW'(1) : din.r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= d_next;
    end
  end

endmodule
